FILE: rtl/dag_pkg.sv
package dag_pkg;

  localparam int unsigned NodesDefault = 64;
  localparam int unsigned EdgesDefault = 1024;
  localparam int unsigned CountWidth   = 7;
  localparam int unsigned NodeWidth    = 6;

  localparam logic OpAddEdge = 1'b0;
  localparam logic OpRun     = 1'b1;

  // Byte address of the node_count register on paddr.
  localparam logic [1:0] RegNodeCount = 2'd0;

  typedef struct packed {
    logic                 opcode;
    logic [NodeWidth-1:0] from_node;
    logic [NodeWidth-1:0] to_node;
  } cmd_t;

  typedef struct packed {
    logic [NodeWidth-1:0] node_index;
    logic                 acyclic;
    logic                 edges_dropped;
    logic                 last;
  } res_t;

endpackage

FILE: rtl/dag_topological_order_top.sv
// DFS topological sort with cycle detection.
//
// Commands enter on start_i/cmd_i and are taken when start_i is high and
// busy_o is low. An add-edge beat is stored, or dropped if the store is full
// or a node is out of range. It gives no result; busy_o stays low, so edge
// loads can arrive one per cycle. A run beat raises busy_o and walks the
// edge store depth first. Every node scans all stored edges, each slot as a
// memory read and a decision, before it finishes; a node with a parent
// then reloads the parent frame from the stack memory. Each root index is
// checked in turn. Then node_count results leave on res_o, one per cycle,
// each marked by res_valid_o for a single cycle; the receiver cannot
// stall them. The final beat has last set. busy_o falls in the cycle that
// shows the final result, and the edge store is then empty.
// Reset clears the edge count, the marks and the flags and sets node_count
// to the parameter maximum. node_count is written over the APB port at
// address 0 and is clamped to 1..MAX_NODES.
module dag_topological_order_top #(
  parameter int unsigned MAX_NODES = dag_pkg::NodesDefault,
  parameter int unsigned MAX_EDGES = dag_pkg::EdgesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  dag_pkg::cmd_t cmd_i,
  output logic         busy_o,
  output logic         res_valid_o,
  output dag_pkg::res_t res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned EW = $clog2(MAX_EDGES);
  localparam int unsigned TW = $clog2(MAX_EDGES + 1);
  localparam int unsigned SW = $clog2(MAX_NODES);
  localparam int unsigned PW = $clog2(MAX_NODES + 1);
  localparam int unsigned NW = dag_pkg::NodeWidth;
  localparam int unsigned CW = dag_pkg::CountWidth;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRoot  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StCheck = 3'd3;
  localparam logic [2:0] StPop   = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  // Configuration.
  logic [CW-1:0] count_q, count_d;
  logic [6:0]    wr_val;
  assign pready = 1'b1;
  assign wr_val = pwdata[6:0];
  always_comb begin
    count_d = count_q;
    if (psel && penable && pwrite && paddr == dag_pkg::RegNodeCount) begin
      if (wr_val == '0) count_d = CW'(1);
      else if (32'(wr_val) > MAX_NODES) count_d = CW'(MAX_NODES);
      else count_d = wr_val;
    end
  end
  assign prdata = (paddr == dag_pkg::RegNodeCount) ? 32'(count_q) : '0;

  // Edge store: one memory holding source and target.
  logic [2*NW-1:0] edge_mem [MAX_EDGES];
  logic [2*NW-1:0] edge_rd_q;
  logic [EW-1:0]   edge_ra;
  logic            edge_we;

  // Walk stack: parent frames of node and resume position; the top frame
  // lives in u_q and e_q.
  logic [NW+TW-1:0] stk_mem [MAX_NODES];
  logic [NW+TW-1:0] stk_rd_q;
  logic             stk_we;
  logic [SW-1:0]    stk_wa;
  logic [SW-1:0]    stk_ra;
  logic [NW+TW-1:0] stk_wd;

  logic [NW-1:0] fin_mem [MAX_NODES];
  logic [NW-1:0] fin_rd_q;
  logic          fin_we;
  logic [SW-1:0] fin_ra;

  logic [MAX_NODES-1:0] seen_q, seen_d, path_q, path_d;
  logic [TW-1:0] total_q, total_d;
  logic          cyc_q, cyc_d, drop_q, drop_d;
  logic [2:0]    st_q, st_d;
  logic [PW-1:0] sp_q, sp_d, nfin_q, nfin_d;
  logic [CW-1:0] root_q, root_d;
  logic [NW-1:0] u_q, u_d;
  logic [TW-1:0] e_q, e_d;
  logic          out_v_q, out_v_d;
  dag_pkg::res_t out_q, out_d;

  logic accept;
  logic [NW-1:0] es, et;
  assign accept = start_i && !busy_o;
  assign busy_o = (st_q != StIdle);
  assign es = edge_rd_q[2*NW-1:NW];
  assign et = edge_rd_q[NW-1:0];

  always_comb begin
    st_d = st_q; seen_d = seen_q; path_d = path_q; total_d = total_q;
    cyc_d = cyc_q; drop_d = drop_q; sp_d = sp_q; nfin_d = nfin_q;
    root_d = root_q; u_d = u_q; e_d = e_q;
    out_v_d = 1'b0; out_d = out_q;
    edge_we = 1'b0; edge_ra = e_q[EW-1:0];
    stk_we = 1'b0; stk_wa = SW'(sp_q - PW'(1)); stk_wd = {u_q, e_q + TW'(1)};
    stk_ra = SW'(sp_q - PW'(2));
    fin_we = 1'b0;
    fin_ra = SW'(nfin_q - PW'(1));
    unique case (st_q)
      StIdle: begin
        if (accept) begin
          if (cmd_i.opcode == dag_pkg::OpAddEdge) begin
            if (32'(total_q) >= MAX_EDGES || CW'(cmd_i.from_node) >= count_q ||
                CW'(cmd_i.to_node) >= count_q) begin
              drop_d = 1'b1;
            end else begin
              edge_we = 1'b1;
              total_d = total_q + TW'(1);
            end
          end else begin
            seen_d = '0; path_d = '0; cyc_d = 1'b0;
            root_d = '0; nfin_d = '0; sp_d = '0;
            st_d = StRoot;
          end
        end
      end
      StRoot: begin
        if (root_q >= count_q) begin
          st_d = StEmit;
        end else if (seen_q[root_q[SW-1:0]]) begin
          root_d = root_q + CW'(1);
        end else begin
          seen_d[root_q[SW-1:0]] = 1'b1;
          path_d[root_q[SW-1:0]] = 1'b1;
          u_d = root_q[NW-1:0]; e_d = '0; sp_d = PW'(1);
          st_d = StRead;
        end
      end
      StRead: begin
        // The edge at e_q is being read; past the end, u_q finishes.
        if (e_q >= total_q) begin
          path_d[u_q[SW-1:0]] = 1'b0;
          fin_we = 1'b1;
          nfin_d = nfin_q + PW'(1);
          sp_d = sp_q - PW'(1);
          if (sp_q == PW'(1)) begin
            root_d = root_q + CW'(1);
            st_d = StRoot;
          end else begin
            st_d = StPop;
          end
        end else begin
          st_d = StCheck;
        end
      end
      StCheck: begin
        st_d = StRead;
        e_d = e_q + TW'(1);
        if (es == u_q && CW'(et) < count_q) begin
          if (path_q[et[SW-1:0]]) begin
            cyc_d = 1'b1;
          end else if (!seen_q[et[SW-1:0]] && 32'(sp_q) < MAX_NODES) begin
            // The parent resumes after this edge once the child finishes.
            stk_we = 1'b1;
            seen_d[et[SW-1:0]] = 1'b1; path_d[et[SW-1:0]] = 1'b1;
            sp_d = sp_q + PW'(1);
            u_d = et; e_d = '0;
          end
        end
      end
      StPop: begin
        u_d = stk_rd_q[NW+TW-1:TW];
        e_d = stk_rd_q[TW-1:0];
        st_d = StRead;
      end
      StEmit: begin
        out_v_d = 1'b1;
        out_d.node_index = fin_rd_q;
        out_d.acyclic = !cyc_q;
        out_d.edges_dropped = drop_q;
        out_d.last = (nfin_q == PW'(1));
        nfin_d = nfin_q - PW'(1);
        fin_ra = SW'(nfin_q - PW'(2));
        if (nfin_q == PW'(1)) begin
          total_d = '0; drop_d = 1'b0; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[total_q[EW-1:0]] <= {cmd_i.from_node, cmd_i.to_node};
    edge_rd_q <= edge_mem[edge_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_q <= stk_mem[stk_ra];
    if (fin_we) fin_mem[nfin_q[SW-1:0]] <= u_q;
    fin_rd_q <= fin_mem[fin_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; count_q <= CW'(MAX_NODES);
      seen_q <= '0; path_q <= '0; total_q <= '0;
      cyc_q <= 1'b0; drop_q <= 1'b0; sp_q <= '0; nfin_q <= '0;
      root_q <= '0; u_q <= '0; e_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; count_q <= count_d;
      seen_q <= seen_d; path_q <= path_d; total_q <= total_d;
      cyc_q <= cyc_d; drop_q <= drop_d; sp_q <= sp_d; nfin_q <= nfin_d;
      root_q <= root_d; u_q <= u_d; e_q <= e_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_v_q;
  assign res_o = out_q;

endmodule

FILE: tb/dag_topological_order_top_tb.sv
module dag_topological_order_top_tb;

  localparam int unsigned Nodes      = dag_pkg::NodesDefault;
  localparam int unsigned Edges      = dag_pkg::EdgesDefault;
  localparam longint      CycleLimit = 4000000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  dag_pkg::cmd_t cmd_i = '0;
  logic          busy_o;
  logic          res_valid_o;
  dag_pkg::res_t res_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [1:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  dag_topological_order_top uut (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .res_valid_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow state of the block.
  logic [dag_pkg::NodeWidth-1:0] edge_from_q [Edges];
  logic [dag_pkg::NodeWidth-1:0] edge_to_q [Edges];
  int unsigned          edge_fill;
  int unsigned          node_limit;
  bit                   dropped_flag;

  dag_pkg::res_t order_expected [$];
  int unsigned mismatches;
  int unsigned runs_done;
  int unsigned edges_sent;
  int unsigned results_seen;
  longint      cycles;
  bit          allow_idle = 1'b1;

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic int unsigned clamp_nodes(input logic [31:0] v);
    int unsigned c;
    c = 32'(v[dag_pkg::CountWidth-1:0]);
    if (c < 1) return 1;
    if (c > Nodes) return Nodes;
    return c;
  endfunction

  task automatic add_edge_model(input dag_pkg::cmd_t c);
    if (edge_fill >= Edges || c.from_node >= node_limit || c.to_node >= node_limit) begin
      dropped_flag = 1'b1;
    end else begin
      edge_from_q[edge_fill] = c.from_node;
      edge_to_q[edge_fill] = c.to_node;
      edge_fill++;
    end
  endtask

  // Depth-first walk with an explicit stack; queues the reverse postorder.
  task automatic predict_order();
    bit          seen [Nodes];
    bit          on_path [Nodes];
    int unsigned stk_node [Nodes];
    int unsigned stk_pos [Nodes];
    int unsigned finished [Nodes];
    int unsigned nfin, sp, u, e, v;
    bit          cyc;
    dag_pkg::res_t r;
    nfin = 0;
    cyc = 1'b0;
    foreach (seen[i]) begin
      seen[i] = 1'b0;
      on_path[i] = 1'b0;
    end
    for (int unsigned root = 0; root < node_limit; root++) begin
      if (seen[root]) continue;
      seen[root] = 1'b1;
      on_path[root] = 1'b1;
      stk_node[0] = root;
      stk_pos[0] = 0;
      sp = 1;
      while (sp > 0) begin
        u = stk_node[sp-1];
        e = stk_pos[sp-1];
        while (e < edge_fill && !(edge_from_q[e] == u && edge_to_q[e] < node_limit)) e++;
        if (e < edge_fill) begin
          v = edge_to_q[e];
          stk_pos[sp-1] = e + 1;
          if (on_path[v]) begin
            cyc = 1'b1;
          end else if (!seen[v] && sp < Nodes) begin
            seen[v] = 1'b1;
            on_path[v] = 1'b1;
            stk_node[sp] = v;
            stk_pos[sp] = 0;
            sp++;
          end
        end else begin
          on_path[u] = 1'b0;
          if (nfin < Nodes) begin
            finished[nfin] = u;
            nfin++;
          end
          sp--;
        end
      end
    end
    for (int unsigned k = 0; k < nfin; k++) begin
      r.node_index = dag_pkg::NodeWidth'(finished[nfin-1-k]);
      r.acyclic = !cyc;
      r.edges_dropped = dropped_flag;
      r.last = (k + 1 == nfin);
      order_expected = {order_expected, r};
    end
    edge_fill = 0;
    dropped_flag = 1'b0;
    runs_done++;
  endtask

  // Holds start high until the beat is taken; busy_o only moves at rising
  // edges, so its value at the falling edge decides the coming edge.
  task automatic send_cmd(input logic op, input int unsigned from_n, input int unsigned to_n);
    dag_pkg::cmd_t c;
    bit   taken;
    c.opcode = op;
    c.from_node = from_n[dag_pkg::NodeWidth-1:0];
    c.to_node = to_n[dag_pkg::NodeWidth-1:0];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      start_i <= 1'b1;
      cmd_i <= c;
      taken = !busy_o;
      @(posedge clk_i);
    end
    if (op == dag_pkg::OpRun) predict_order();
    else begin
      add_edge_model(c);
      edges_sent++;
    end
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (order_expected.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_node_count(input logic [31:0] v);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= dag_pkg::RegNodeCount;
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    node_limit = clamp_nodes(v);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[dag_pkg::CountWidth-1:0] !== node_limit[dag_pkg::CountWidth-1:0])
      report($sformatf("node_count read %0d, want %0d", prdata, node_limit));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("dag_topological_order_top_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    dag_pkg::res_t want;
    if (rst_ni && res_valid_o === 1'b1) begin
      results_seen++;
      if (order_expected.size() == 0) begin
        report($sformatf("unexpected result node %0d", res_o.node_index));
      end else begin
        want = order_expected.pop_front();
        if (res_o.node_index !== want.node_index)
          report($sformatf("node_index %0d, want %0d", res_o.node_index, want.node_index));
        if (res_o.acyclic !== want.acyclic)
          report($sformatf("acyclic %0b, want %0b", res_o.acyclic, want.acyclic));
        if (res_o.edges_dropped !== want.edges_dropped)
          report($sformatf("edges_dropped %0b, want %0b",
                           res_o.edges_dropped, want.edges_dropped));
        if (res_o.last !== want.last)
          report($sformatf("last %0b, want %0b", res_o.last, want.last));
      end
    end
  end

  task automatic test_directed();
    send_cmd(dag_pkg::OpRun, 0, 0);          // empty graph at the reset count
    send_cmd(dag_pkg::OpAddEdge, 63, 0);
    send_cmd(dag_pkg::OpAddEdge, 0, 63);     // closes a two-node cycle
    send_cmd(dag_pkg::OpAddEdge, 5, 5);      // self loop
    send_cmd(dag_pkg::OpRun, 0, 0);
    set_node_count(32'd0);                   // clamps to one node
    send_cmd(dag_pkg::OpAddEdge, 0, 0);
    send_cmd(dag_pkg::OpAddEdge, 1, 0);      // out of range, dropped
    send_cmd(dag_pkg::OpRun, 0, 0);
    set_node_count(32'd127);                 // clamps to the maximum
    set_node_count(32'hFFFF_FF80);           // only the low bits count, so zero, which clamps to one node
    set_node_count(32'd3);
    send_cmd(dag_pkg::OpAddEdge, 0, 1);
    send_cmd(dag_pkg::OpAddEdge, 0, 2);
    send_cmd(dag_pkg::OpAddEdge, 2, 1);
    send_cmd(dag_pkg::OpAddEdge, 2, 3);      // dropped
    send_cmd(dag_pkg::OpRun, 0, 0);
  endtask

  // Edges loaded under a larger count, then run with a smaller one.
  task automatic test_shrunk_count();
    set_node_count(32'd64);
    send_cmd(dag_pkg::OpAddEdge, 1, 40);
    send_cmd(dag_pkg::OpAddEdge, 2, 1);
    send_cmd(dag_pkg::OpAddEdge, 45, 3);
    send_cmd(dag_pkg::OpAddEdge, 3, 2);
    set_node_count(32'd8);
    send_cmd(dag_pkg::OpRun, 0, 0);
  endtask

  task automatic test_random_graphs(input int unsigned items);
    int unsigned sent, n, ne, a, b;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(0, 5) == 0) ? Nodes : $urandom_range(1, 16);
      set_node_count(n);
      ne = $urandom_range(0, 3 * n);
      if (ne > 40) ne = 40;
      for (int unsigned i = 0; i < ne; i++) begin
        case ($urandom_range(0, 9))
          0: begin                       // noise, often out of range
            a = $urandom_range(0, 63);
            b = $urandom_range(0, 63);
          end
          1, 2: begin                    // possible back edge
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
          end
          default: begin                 // mostly forward edges; from the last node it may point back to 0
            a = $urandom_range(0, n - 1);
            b = (a + 1 < n) ? $urandom_range(a + 1, n - 1) : a;
            if (a == b) b = $urandom_range(0, n - 1) == 0 ? a : 0;
            if (a == b && n > 1) a = 0;
          end
        endcase
        send_cmd(dag_pkg::OpAddEdge, a, b);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) drain();
      send_cmd(dag_pkg::OpRun, 0, 0);
      sent++;
    end
  endtask

  initial begin
    edge_fill = 0;
    node_limit = Nodes;
    dropped_flag = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_shrunk_count();
    test_random_graphs(310);
    allow_idle = 1'b0;
    test_random_graphs(60);
    drain();
    repeat (50) @(posedge clk_i);
    if (order_expected.size() != 0)
      report($sformatf("%0d results never arrived", order_expected.size()));
    $display("covered %0d edge beats and %0d sort runs, %0d results checked",
             edges_sent, runs_done, results_seen);
    $display("node counts from 1 to 64, cycles, self loops and dropped edges");
    if (mismatches == 0) begin
      $display("dag_topological_order_top_tb: PASS");
    end else begin
      $display("dag_topological_order_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dag_pkg.sv
rtl/dag_topological_order_top.sv
tb/dag_topological_order_top_tb.sv
